### hdl/cds_pkg.sv
package cds_pkg;

  localparam int LINES_DEFAULT = 2;
  localparam int CPL_DEFAULT   = 16;

  // Width of line * CHARS_PER_LINE + column before saturation (holds up to 127)
  localparam int SET_IDX_W  = 7;
  localparam int COUNT_W    = 8;
  localparam int NUM_W      = 16;
  localparam int NUM_DIGITS = 5;

  localparam logic [2:0] DIGIT_LAST = 3'(NUM_DIGITS - 1);

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam logic [2:0] OP_WRITE_CHAR   = 3'd0;
  localparam logic [2:0] OP_SET_CURSOR   = 3'd1;
  localparam logic [2:0] OP_ADVANCE      = 3'd2;
  localparam logic [2:0] OP_CLEAR        = 3'd3;
  localparam logic [2:0] OP_BLANK        = 3'd4;
  localparam logic [2:0] OP_REFRESH      = 3'd5;
  localparam logic [2:0] OP_WRITE_NUMBER = 3'd6;

  typedef struct packed {
    logic [2:0]       operation;
    logic [7:0]       char_code;
    logic [1:0]       line;
    logic [3:0]       column;
    logic [COUNT_W-1:0] count;
    logic [NUM_W-1:0] number;
    logic             keep_zeros;
  } cmd_t;

  typedef struct packed {
    logic [1:0] out_line;
    logic [3:0] out_column;
    logic [7:0] out_char;
    logic       cell_valid;
    logic       last;
  } res_t;

  // mult * 10^(4 - place), place 0 is the ten-thousands digit
  function automatic logic [NUM_W:0] dec_multiple(input logic [2:0] place,
                                                  input logic [3:0] mult);
    logic [NUM_W:0] pw;
    case (place)
      3'd0:    pw = 17'd10000;
      3'd1:    pw = 17'd1000;
      3'd2:    pw = 17'd100;
      3'd3:    pw = 17'd10;
      default: pw = 17'd1;
    endcase
    return 17'(pw * {13'd0, mult});
  endfunction

endpackage

### hdl/char_display_shadow_buffer_unit.sv
// Character display buffer with a shadow copy for dirty tracking.
// Command items enter on cmd_valid/cmd_ready as one cmd_t; result items
// leave on res_valid/res_ready as one res_t. Only a refresh makes results:
// one per changed cell in ascending cell order, last set on the final one,
// or a single empty result (cell_valid 0, last 1) when nothing changed.
// Pace per item, N = LINES * CHARS_PER_LINE cells:
//   write char, set cursor, advance, unused code: handled in the accept cycle.
//   clear, blank: one cell write per cycle over all N cells.
//   write number: one digit per cycle.
//   refresh: the scan reads one cell and its shadow per cycle from the two
//   RAMs, and waits while the receiver stalls.
// The cell RAM and the shadow RAM each have one write and one registered
// read port; that port pair sets the one-cell-per-cycle pace.
// After reset a clearing pass over all N cells zeroes both RAMs;
// cmd_ready stays low until it ends. The cursor resets to cell 0.
// A stalled receiver holds the output register; the scan then waits on the
// next changed cell until the register frees up. A new command may be taken
// while the final result of a refresh still waits in the output register.
module char_display_shadow_buffer_unit import cds_pkg::*; #(
  parameter int LINES          = LINES_DEFAULT,
  parameter int CHARS_PER_LINE = CPL_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int NUM_CELLS = LINES * CHARS_PER_LINE;
  localparam int CW        = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int MW        = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [CW-1:0] LAST_CELL = CW'(NUM_CELLS - 1);
  localparam logic [SET_IDX_W-1:0] LAST_SET = SET_IDX_W'(NUM_CELLS - 1);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_NUMBER,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t         state;
  logic [CW-1:0]  cursor;

  // clear / blank / post-reset sweep
  logic [CW-1:0]  sweep_idx;
  logic [7:0]     sweep_char;
  logic           sweep_shadow;

  // refresh scan
  logic [CW-1:0]  issue_idx;
  logic           issue_more;
  logic [CW-1:0]  cmp_idx;
  logic           cmp_vld;
  logic [CW-1:0]  pend_idx;
  logic [7:0]     pend_char;
  logic           pend_vld;

  // decimal conversion
  logic [2:0]       digit_place;
  logic [NUM_W-1:0] rem;
  logic             started;
  logic             keep;

  // RAM ports
  logic          cell_we, shadow_we;
  logic [CW-1:0] cell_waddr, shadow_waddr, rd_addr;
  logic [7:0]    cell_wdata, shadow_wdata, cell_rdata, shadow_rdata;

  logic                 accept;
  logic [CW-1:0]        cur_inc, cursor_fwd, cursor_set;
  logic [SET_IDX_W-1:0] set_idx;
  logic [3:0]           digit;
  logic [NUM_W:0]       digit_sub;
  logic                 write_digit;
  logic                 diff, out_free, stall;
  logic                 res_load;

  // Split the cell index into line and column by comparing with line starts
  function automatic res_t make_res(input logic [CW-1:0] idx, input logic [7:0] ch,
                                    input logic last_flag);
    res_t          r;
    logic [CW-1:0] base;
    r.out_line = 2'd0;
    base       = '0;
    for (int l = 1; l < LINES; l++) begin
      if (idx >= CW'(l * CHARS_PER_LINE)) begin
        r.out_line = 2'(l);
        base       = CW'(l * CHARS_PER_LINE);
      end
    end
    r.out_column = 4'(idx - base);
    r.out_char   = ch;
    r.cell_valid = 1'b1;
    r.last       = last_flag;
    return r;
  endfunction

  cds_ram #(.WIDTH(8), .DEPTH(NUM_CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (rd_addr),
    .rdata (cell_rdata)
  );

  cds_ram #(.WIDTH(8), .DEPTH(NUM_CELLS)) u_shadow_ram (
    .clk   (clk),
    .we    (shadow_we),
    .waddr (shadow_waddr),
    .wdata (shadow_wdata),
    .raddr (rd_addr),
    .rdata (shadow_rdata)
  );

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid & cmd_ready;

  // Cursor moves; all saturate at the last cell
  always_comb begin
    cur_inc = (cursor == LAST_CELL) ? LAST_CELL : cursor + CW'(1);
    cursor_fwd = (MW'(LAST_CELL - cursor) > MW'(cmd.count)) ?
                 cursor + CW'(cmd.count) : LAST_CELL;
    set_idx = SET_IDX_W'(cmd.line) * SET_IDX_W'(CHARS_PER_LINE) + SET_IDX_W'(cmd.column);
    cursor_set = (set_idx > LAST_SET) ? LAST_CELL : CW'(set_idx);
  end

  // One decimal digit per cycle: largest multiple of the place value that fits
  always_comb begin
    digit = 4'd0;
    for (int m = 1; m <= 9; m++) begin
      if ({1'b0, rem} >= dec_multiple(digit_place, 4'(m))) begin
        digit = 4'(m);
      end
    end
    digit_sub   = dec_multiple(digit_place, digit);
    write_digit = started | keep | (digit != 4'd0) | (digit_place == DIGIT_LAST);
  end

  // Scan: compare stage waits when a second changed cell finds the output busy
  assign diff     = (cell_rdata != shadow_rdata);
  assign out_free = !res_valid || res_ready;
  assign stall    = cmp_vld && diff && pend_vld && !out_free;
  assign rd_addr  = stall ? cmp_idx : issue_idx;

  // Load the output register with a held-back cell or the closing result
  assign res_load = ((state == S_SCAN) && cmp_vld && diff && pend_vld && !stall) ||
                    ((state == S_FLUSH) && out_free);

  always_comb begin
    cell_we      = 1'b0;
    cell_waddr   = cursor;
    cell_wdata   = cmd.char_code;
    shadow_we    = 1'b0;
    shadow_waddr = cmp_idx;
    shadow_wdata = cell_rdata;
    unique case (state)
      S_SWEEP: begin
        cell_we      = 1'b1;
        cell_waddr   = sweep_idx;
        cell_wdata   = sweep_char;
        shadow_we    = sweep_shadow;
        shadow_waddr = sweep_idx;
        shadow_wdata = 8'd0;
      end
      S_IDLE: begin
        cell_we = accept && (cmd.operation == OP_WRITE_CHAR);
      end
      S_NUMBER: begin
        cell_we    = write_digit;
        cell_wdata = CHAR_ZERO + 8'(digit);
      end
      S_SCAN: begin
        shadow_we = cmp_vld && diff && !stall;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      cursor       <= '0;
      sweep_idx    <= '0;
      sweep_char   <= 8'd0;
      sweep_shadow <= 1'b1;
      issue_more   <= 1'b0;
      cmp_vld      <= 1'b0;
      pend_vld     <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          sweep_idx <= sweep_idx + CW'(1);
          if (sweep_idx == LAST_CELL) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (cmd.operation)
              OP_WRITE_CHAR:   cursor <= cur_inc;
              OP_SET_CURSOR:   cursor <= cursor_set;
              OP_ADVANCE:      cursor <= cursor_fwd;
              OP_CLEAR: begin
                sweep_idx    <= '0;
                sweep_char   <= CHAR_SPACE;
                sweep_shadow <= 1'b1;
                state        <= S_SWEEP;
              end
              OP_BLANK: begin
                sweep_idx    <= '0;
                sweep_char   <= CHAR_SPACE;
                sweep_shadow <= 1'b0;
                state        <= S_SWEEP;
              end
              OP_REFRESH: begin
                issue_idx  <= '0;
                issue_more <= 1'b1;
                cmp_vld    <= 1'b0;
                pend_vld   <= 1'b0;
                state      <= S_SCAN;
              end
              OP_WRITE_NUMBER: begin
                rem         <= cmd.number;
                digit_place <= '0;
                started     <= 1'b0;
                keep        <= cmd.keep_zeros;
                state       <= S_NUMBER;
              end
              default: begin
              end
            endcase
          end
        end
        S_NUMBER: begin
          rem         <= rem - digit_sub[NUM_W-1:0];
          started     <= write_digit;
          digit_place <= digit_place + 3'd1;
          if (write_digit) begin
            cursor <= cur_inc;
          end
          if (digit_place == DIGIT_LAST) begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (!stall) begin
            // hold one changed cell back so the final one can carry last
            if (cmp_vld && diff) begin
              if (pend_vld) begin
                res <= make_res(pend_idx, pend_char, 1'b0);
              end
              pend_vld  <= 1'b1;
              pend_idx  <= cmp_idx;
              pend_char <= cell_rdata;
            end
            if (issue_more) begin
              cmp_idx   <= issue_idx;
              cmp_vld   <= 1'b1;
              issue_idx <= issue_idx + CW'(1);
              if (issue_idx == LAST_CELL) begin
                issue_more <= 1'b0;
              end
            end else begin
              cmp_vld <= 1'b0;
              if (!cmp_vld) begin
                state <= S_FLUSH;
              end
            end
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            if (pend_vld) begin
              res <= make_res(pend_idx, pend_char, 1'b1);
            end else begin
              res <= '{out_line: 2'd0, out_column: 4'd0, out_char: 8'd0,
                       cell_valid: 1'b0, last: 1'b1};
            end
            pend_vld <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/cds_ram.sv
module cds_ram import cds_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
